// File: rtl/pbrf_pkg.sv
// ----------------------------------------------------------------------------
// pbrf_pkg
// Shared types and constants for the bisection root finder.
// ----------------------------------------------------------------------------
package pbrf_pkg;

   localparam int DataWidth      = 32;
   localparam int DegWidth       = 3;
   localparam int TolWidth       = 31;
   localparam int NumCoef        = 6;
   localparam int MaxStepsDef    = 64;
   localparam int MaxDegreeDef   = 5;
   localparam int FracBitsDef    = 16;
   localparam int AddrWidth      = 5;

   // register addresses (byte)
   localparam logic [AddrWidth-1:0] AddrDegree    = 5'd0;
   localparam logic [AddrWidth-1:0] AddrCoef0     = 5'd4;
   localparam logic [AddrWidth-1:0] AddrCoef1     = 5'd8;
   localparam logic [AddrWidth-1:0] AddrCoef2     = 5'd12;
   localparam logic [AddrWidth-1:0] AddrCoef3     = 5'd16;
   localparam logic [AddrWidth-1:0] AddrCoef4     = 5'd20;
   localparam logic [AddrWidth-1:0] AddrCoef5     = 5'd24;
   localparam logic [AddrWidth-1:0] AddrTolerance = 5'd28;

   // request and result payloads
   typedef struct packed {
      logic signed [DataWidth-1:0] left_end;
      logic signed [DataWidth-1:0] right_end;
   } interval_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] root_value;
      logic                        root_found;
   } root_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture interval
      logic mid;         // form midpoint
      logic ev_start;    // start Horner at x (sel_left picks l else m)
      logic sel_left;
      logic ev_step;     // one Horner step
      logic ev_mul;      // register product
      logic save_fm;     // keep f(m)
      logic narrow;      // update l or r using f(m), f(l)
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ev_last;     // no Horner steps left
      logic within_tol;  // |f(m)| <= tolerance
   } status_type;

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[DataWidth-1:0];
   endfunction

endpackage

// File: rtl/pbrf_if.sv
// ----------------------------------------------------------------------------
// pbrf_if
// Valid/ready channel carrying a payload of type T.
// ----------------------------------------------------------------------------
interface pbrf_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pbrf_datapath.sv
// ----------------------------------------------------------------------------
// pbrf_datapath
// Interval registers, midpoint, Horner evaluation on one shared multiplier.
// ----------------------------------------------------------------------------
module pbrf_datapath
   import pbrf_pkg::*;
#(
   parameter int MAX_DEGREE = MaxDegreeDef,
   parameter int FRAC_BITS  = FracBitsDef
) (
   input  logic                        clock,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic signed [DataWidth-1:0] left_in,
   input  logic signed [DataWidth-1:0] right_in,
   input  logic [DegWidth-1:0]         degree,
   input  logic signed [DataWidth-1:0] coef [NumCoef],
   input  logic [TolWidth-1:0]         tolerance,
   output logic signed [DataWidth-1:0] mid_value
);

   logic signed [DataWidth-1:0] l_ff, r_ff, m_ff, x_ff, acc_ff, fm_ff;
   logic signed [63:0]          prod_ff;
   logic [DegWidth-1:0]         idx_ff;
   logic [DegWidth-1:0]         deg_eff;
   logic signed [32:0]          diff;
   logic signed [63:0]          fl;
   logic signed [DataWidth-1:0] sh;
   logic [DegWidth-1:0]         idx_in;
   logic signed [DataWidth:0]   fm_mag;

   assign deg_eff = (degree > DegWidth'(MAX_DEGREE)) ? DegWidth'(MAX_DEGREE) : degree;
   assign diff    = {r_ff[31], r_ff} - {l_ff[31], l_ff};
   // arithmetic shift floors, matching the rounding of the Horner step
   assign fl      = prod_ff >>> FRAC_BITS;
   assign sh      = sat32(66'(fl));
   assign idx_in  = idx_ff - 3'd1;
   assign fm_mag  = acc_ff[31] ? -{acc_ff[31], acc_ff} : {acc_ff[31], acc_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         l_ff <= left_in;
         r_ff <= right_in;
      end
      if (cmd.mid) begin
         // truncating divide by two
         m_ff <= 32'(({l_ff[31], l_ff}) + ((diff + 33'(diff[32])) >>> 1));
      end
      if (cmd.ev_start) begin
         x_ff   <= cmd.sel_left ? l_ff : m_ff;
         acc_ff <= coef[deg_eff];
         idx_ff <= deg_eff;
      end
      if (cmd.ev_mul) prod_ff <= acc_ff * x_ff;
      if (cmd.ev_step) begin
         acc_ff <= sat32(66'(sh) + 66'(coef[idx_in]));
         idx_ff <= idx_in;
      end
      if (cmd.save_fm) fm_ff <= acc_ff;
      if (cmd.narrow) begin
         if ((fm_ff[31] && acc_ff > 0) || (fm_ff > 0 && acc_ff[31])) r_ff <= m_ff;
         else l_ff <= m_ff;
      end
   end

   assign status.ev_last    = (idx_ff == '0);
   assign status.within_tol = fm_mag <= $signed({2'b00, tolerance});
   assign mid_value         = m_ff;

endmodule

// File: rtl/pbrf_ctrl.sv
// ----------------------------------------------------------------------------
// pbrf_ctrl
// Sequencer for bisection steps and Horner evaluation.
// ----------------------------------------------------------------------------
module pbrf_ctrl
   import pbrf_pkg::*;
#(
   parameter int MAX_STEPS = MaxStepsDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output logic       found,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int SW = $clog2(MAX_STEPS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MID   = 4'd1;
   localparam logic [3:0] S_EVM   = 4'd2;
   localparam logic [3:0] S_MULM  = 4'd3;
   localparam logic [3:0] S_ADDM  = 4'd4;
   localparam logic [3:0] S_TEST  = 4'd5;
   localparam logic [3:0] S_EVL   = 4'd6;
   localparam logic [3:0] S_MULL  = 4'd7;
   localparam logic [3:0] S_ADDL  = 4'd8;
   localparam logic [3:0] S_NARR  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic          found_ff, found_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      found_in = found_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: if (in_valid) begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = S_MID;
         end
         S_MID: begin
            cmd.mid  = 1'b1;
            step_in  = step_ff + 1'b1;
            state_in = S_EVM;
         end
         S_EVM: begin
            cmd.ev_start = 1'b1;
            state_in     = S_MULM;
         end
         S_MULM: begin
            if (status.ev_last) state_in = S_TEST;
            else begin
               cmd.ev_mul = 1'b1;
               state_in   = S_ADDM;
            end
         end
         S_ADDM: begin
            cmd.ev_step = 1'b1;
            state_in    = S_MULM;
         end
         S_TEST: begin
            cmd.save_fm = 1'b1;
            if (status.within_tol) begin
               found_in = 1'b1;
               state_in = S_OUT;
            end else if (step_ff == SW'(MAX_STEPS)) begin
               found_in = 1'b0;
               state_in = S_OUT;
            end else state_in = S_EVL;
         end
         S_EVL: begin
            cmd.ev_start = 1'b1;
            cmd.sel_left = 1'b1;
            state_in     = S_MULL;
         end
         S_MULL: begin
            if (status.ev_last) state_in = S_NARR;
            else begin
               cmd.ev_mul = 1'b1;
               state_in   = S_ADDL;
            end
         end
         S_ADDL: begin
            cmd.ev_step = 1'b1;
            state_in    = S_MULL;
         end
         S_NARR: begin
            cmd.narrow = 1'b1;
            state_in   = S_MID;
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         found_ff <= found_in;
      end
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign found     = found_ff;

`ifndef ASSERT_OFF
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= SW'(MAX_STEPS)) else $error("step count overflow");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("accept during result");
`endif

endmodule

// File: rtl/polynomial_bisection_root_finder.sv
// ----------------------------------------------------------------------------
// polynomial_bisection_root_finder
// Bisection root finder over a configurable polynomial, signed Q16.16.
// ----------------------------------------------------------------------------
// One interval at a time. Each bisection step forms the midpoint, evaluates
// f(m), tests it and, unless it ends, evaluates f(l) and narrows the
// interval; all Horner steps share one 32x32 multiplier.
module polynomial_bisection_root_finder
   import pbrf_pkg::*;
#(
   parameter int MAX_STEPS  = MaxStepsDef,
   parameter int MAX_DEGREE = MaxDegreeDef,
   parameter int FRAC_BITS  = FracBitsDef
) (
   input  logic                 clock,
   input  logic                 reset,
   pbrf_if.sink                 req,
   pbrf_if.source               rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   logic [DegWidth-1:0]         degree_ff;
   logic signed [DataWidth-1:0] coef_ff [NumCoef];
   logic [TolWidth-1:0]         tol_ff;
   logic                        wr;
   cmd_type                     cmd;
   status_type                  status;
   logic                        found;
   logic signed [DataWidth-1:0] mid_value;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd1;
         coef_ff[0] <= '0;
         coef_ff[1] <= 32'sd65536;
         coef_ff[2] <= '0;
         coef_ff[3] <= '0;
         coef_ff[4] <= '0;
         coef_ff[5] <= '0;
         tol_ff <= 31'd7;
      end else if (wr) begin
         unique case (csr_paddr)
            AddrDegree:    degree_ff  <= csr_pwdata[DegWidth-1:0];
            AddrCoef0:     coef_ff[0] <= csr_pwdata;
            AddrCoef1:     coef_ff[1] <= csr_pwdata;
            AddrCoef2:     coef_ff[2] <= csr_pwdata;
            AddrCoef3:     coef_ff[3] <= csr_pwdata;
            AddrCoef4:     coef_ff[4] <= csr_pwdata;
            AddrCoef5:     coef_ff[5] <= csr_pwdata;
            AddrTolerance: tol_ff     <= csr_pwdata[TolWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         AddrDegree:    csr_prdata = {29'd0, degree_ff};
         AddrCoef0:     csr_prdata = coef_ff[0];
         AddrCoef1:     csr_prdata = coef_ff[1];
         AddrCoef2:     csr_prdata = coef_ff[2];
         AddrCoef3:     csr_prdata = coef_ff[3];
         AddrCoef4:     csr_prdata = coef_ff[4];
         AddrCoef5:     csr_prdata = coef_ff[5];
         AddrTolerance: csr_prdata = {1'b0, tol_ff};
         default:       csr_prdata = '0;
      endcase
   end

   pbrf_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .found, .cmd, .status
   );

   pbrf_datapath #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .cmd, .status,
      .left_in(req.data.left_end), .right_in(req.data.right_end),
      .degree(degree_ff), .coef(coef_ff), .tolerance(tol_ff), .mid_value
   );

   assign rsp.data.root_value = mid_value;
   assign rsp.data.root_found = found;

endmodule

// File: test/pbrf_test_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbrf_test_pkg
// Register indexes shared by the root finder test files.
// ----------------------------------------------------------------------------
package pbrf_test_pkg;

   typedef enum logic [2:0] {
      RegDegree    = 3'd0,
      RegCoef0     = 3'd1,
      RegCoef1     = 3'd2,
      RegCoef2     = 3'd3,
      RegCoef3     = 3'd4,
      RegCoef4     = 3'd5,
      RegCoef5     = 3'd6,
      RegTolerance = 3'd7
   } reg_index_type;

endpackage

// File: test/pbrf_root_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbrf_root_checker
// Tracks register writes, predicts the root for each accepted interval and
// compares it with each result transfer in order.
// ----------------------------------------------------------------------------
module pbrf_root_checker
   import pbrf_pkg::*;
   import pbrf_test_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  interval_type    req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  root_type        rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic            csr_pready,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output int              pending_roots,
   output int              mismatch_count,
   output int              roots_checked,
   output int              roots_found
);

   logic [2:0]         degree_q;
   logic signed [31:0] coef_q [NumCoef];
   logic [30:0]        tol_q;
   root_type           expected_roots[$];

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] poly_at(input logic signed [31:0] x);
      int                 d;
      logic signed [31:0] acc;
      longint             prod;
      d = (degree_q > MaxDegreeDef) ? MaxDegreeDef : degree_q;
      acc = coef_q[d];
      for (int i = d - 1; i >= 0; i--) begin
         prod = longint'(acc) * longint'(x);
         acc = clamp32(prod >>> FracBitsDef);   // arithmetic shift = floor
         acc = clamp32(longint'(acc) + longint'(coef_q[i]));
      end
      return acc;
   endfunction

   function automatic root_type bisect(input interval_type iv);
      logic signed [31:0] l, r, m, fm, fl;
      longint             diff, mag;
      root_type           res;
      l = iv.left_end;
      r = iv.right_end;
      m = l;
      for (int s = 0; s < MaxStepsDef; s++) begin
         diff = longint'(r) - longint'(l);
         m = 32'(longint'(l) + diff / 2);       // truncates toward zero
         fm = poly_at(m);
         mag = (fm < 0) ? -longint'(fm) : longint'(fm);
         if (mag <= longint'({1'b0, tol_q})) begin
            res.root_value = m;
            res.root_found = 1'b1;
            return res;
         end
         fl = poly_at(l);
         if ((fm < 0 && fl > 0) || (fm > 0 && fl < 0)) r = m;
         else l = m;
      end
      res.root_value = m;
      res.root_found = 1'b0;
      return res;
   endfunction

   assign pending_roots = expected_roots.size();

   always @(posedge clock) begin
      root_type want;
      if (reset) begin
         degree_q <= 3'd1;
         coef_q   <= '{32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
         tol_q    <= 31'd7;
         expected_roots.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               RegDegree:    degree_q <= csr_pwdata[2:0];
               RegTolerance: tol_q <= csr_pwdata[30:0];
               default:      coef_q[csr_paddr[4:2] - 1] <= csr_pwdata;
            endcase
         end
         if (req_valid && req_ready)
            expected_roots.push_back(bisect(req_data));
         if (rsp_valid && rsp_ready) begin
            roots_checked++;
            if (rsp_data.root_found) roots_found++;
            if (expected_roots.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result transfer with no interval pending: %0d/%0b",
                           $time, rsp_data.root_value, rsp_data.root_found);
            end else begin
               want = expected_roots.pop_front();
               if (want.root_value !== rsp_data.root_value ||
                   want.root_found !== rsp_data.root_found) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: root mismatch, expected %0d/%0b, got %0d/%0b",
                              $time, want.root_value, want.root_found,
                              rsp_data.root_value, rsp_data.root_found);
               end
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      roots_checked  = 0;
      roots_found    = 0;
   end

endmodule

// File: test/polynomial_bisection_root_finder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_bisection_root_finder_test
// Drives intervals and register settings into the root finder; a checker
// beside the block predicts each root and compares the results.
// ----------------------------------------------------------------------------
module polynomial_bisection_root_finder_test;
   import pbrf_pkg::*;
   import pbrf_test_pkg::*;

   localparam int One = 65536;

   logic                 clock;
   logic                 reset;
   logic                 csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [AddrWidth-1:0] csr_paddr;
   logic [31:0]          csr_pwdata, csr_prdata;
   int                   pending_roots, mismatch_count, roots_checked, roots_found;
   int                   item_count;
   int                   setting_count;

   pbrf_if #(.T(interval_type)) req_if ();
   pbrf_if #(.T(root_type))     rsp_if ();

   polynomial_bisection_root_finder DUT (
      .clock, .reset, .req(req_if), .rsp(rsp_if),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   pbrf_root_checker checker_i (
      .clock, .reset,
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_data(req_if.data),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_data(rsp_if.data),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .pending_roots, .mismatch_count, .roots_checked, .roots_found
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, one long hold-off, one stretch always ready
   initial begin
      int cyc;
      rsp_if.ready <= 1'b0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 20000 && cyc < 24000) rsp_if.ready <= 1'b0;
         else if (cyc >= 60000 && cyc < 90000) rsp_if.ready <= 1'b1;
         else rsp_if.ready <= ($urandom_range(99) >= 26);
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_interval(input logic signed [31:0] l, input logic signed [31:0] r);
      // no sender gaps over a stretch in the middle of the run
      if (item_count < 300 || item_count >= 400)
         while ($urandom_range(99) < 26) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      req_if.valid <= 1'b1;
      req_if.data  <= '{left_end: l, right_end: r};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      item_count++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_roots != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] deg, input logic signed [31:0] c0,
                            input logic signed [31:0] c1, input logic signed [31:0] c2,
                            input logic signed [31:0] c3, input logic signed [31:0] c4,
                            input logic signed [31:0] c5, input logic [30:0] tol);
      drain();
      csr_write(RegDegree, {29'd0, deg});
      csr_write(RegCoef0, c0);
      csr_write(RegCoef1, c1);
      csr_write(RegCoef2, c2);
      csr_write(RegCoef3, c3);
      csr_write(RegCoef4, c4);
      csr_write(RegCoef5, c5);
      csr_write(RegTolerance, {1'b0, tol});
      setting_count++;
   endtask

   // mostly short intervals around the roots, some full range, some odd ones
   task automatic random_intervals(input int n);
      logic signed [31:0] a, b;
      int                 kind;
      repeat (n) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            a = -$signed($urandom_range(8 * One));
            b = $signed($urandom_range(8 * One));
            if ($urandom_range(1)) begin
               a = -a;
               b = -b;
            end
         end else if (kind < 90) begin
            a = $urandom;
            b = $urandom;
         end else if (kind < 95) begin
            a = $urandom;
            b = a;
         end else begin
            a = $signed($urandom_range(8 * One));
            b = -$signed($urandom_range(8 * One));
         end
         send_interval(a, b);
      end
   endtask

   initial begin
      item_count    = 0;
      setting_count = 1;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting f(x) = x: field extremes, reversed and equal ends
      send_interval(32'sh80000000, 32'sh7fffffff);
      send_interval(32'sh7fffffff, 32'sh80000000);
      send_interval(32'sh80000000, 32'sh80000000);
      send_interval(32'sh7fffffff, 32'sh7fffffff);
      send_interval(0, 0);
      send_interval(-One, One);
      send_interval(5 * One, -3 * One);
      send_interval(2 * One, 7 * One);
      send_interval(-1, 1);
      send_interval(32'sh55555555, 32'shaaaaaaaa);
      random_intervals(40);

      // x^2 - 2
      configure(3'd2, -2 * One, 0, One, 0, 0, 0, 31'd7);
      random_intervals(130);

      // x^3 - x - 1, looser tolerance
      configure(3'd3, -One, -One, 0, One, 0, 0, 31'd64);
      random_intervals(130);

      // constant polynomial, zero tolerance: never within tolerance
      configure(3'd0, 5, 0, 0, 0, 0, 0, 31'd0);
      random_intervals(100);

      // degree 5 with saturating coefficients
      configure(3'd5, $urandom, $urandom, $urandom, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 31'd0);
      send_interval(32'sh80000000, 32'sh7fffffff);
      random_intervals(90);

      // degree above limit, widest tolerance
      configure(3'd7, 32'sh80000000, $urandom, $urandom, $urandom, $urandom,
                $urandom, 31'h7fffffff);
      random_intervals(80);

      // steep line with the most negative offset
      configure(3'd1, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 31'd1000);
      random_intervals(120);

      drain();
      repeat (50) @(posedge clock);
      $display("Checked %0d roots (%0d within tolerance) over %0d register settings",
               roots_checked, roots_found, setting_count);
      $display("Settings spanned degrees 0 to 7, saturating coefficients, zero and full tolerance");
      if (mismatch_count == 0 && pending_roots == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
